// ===== rtl/rrip_pkg.sv =====
// ----------------------------------------------------------------------------
// rrip_pkg
// shared constants and types for the rrip replacement engine
// ----------------------------------------------------------------------------
package rrip_pkg;

	localparam int NUM_SETS     = 2048;
	localparam int NUM_WAYS     = 16;
	localparam int LEADER_PAIRS = 64;

	localparam int SET_W    = 11;
	localparam int WAY_W    = 4;
	localparam int ROW_W    = 2 * NUM_WAYS;
	localparam int STRIDE   = NUM_SETS / LEADER_PAIRS;
	localparam int STRIDE_W = $clog2(STRIDE);
	localparam int PTR_W    = SET_W + 1;

	localparam logic [9:0]  PSEL_MAX  = 10'd1023;
	localparam logic [9:0]  PSEL_MID  = 10'd512;
	localparam logic [11:0] UPD_LAST  = 12'hFFF;

	localparam logic FUNC_VICTIM = 1'b0;
	localparam logic FUNC_UPDATE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SWEEP,
		ST_READ,
		ST_EXEC,
		ST_AGE,
		ST_OUT
	} state_t;

endpackage

// ===== rtl/rrip_reuse_dueling_replacement_top.sv =====
// ----------------------------------------------------------------------------
// rrip_reuse_dueling_replacement_top
// rrip replacement engine with reuse counters and lip/bip set dueling
// ----------------------------------------------------------------------------
// victim request with an invalid way has its result valid in the cycle after the
// input transfer; a full set goes through the exec and age states to out; an update through exec
// every 4096th update first runs a reuse counter sweep over all sets and a row reread
// after reset a clearing pass fills both row memories; in_ready low
// throughput: one item at a time, one result transfer per victim request
module rrip_reuse_dueling_replacement_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      func,
	input  logic [rrip_pkg::SET_W-1:0] set_index,
	input  logic [rrip_pkg::WAY_W-1:0] way_index,
	input  logic                      hit,
	input  logic [15:0]               valid_mask,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rrip_pkg::WAY_W-1:0] victim_way
);
	import rrip_pkg::*;

	state_t state_q, state_d;

	// latched item
	logic             func_q;
	logic [SET_W-1:0] set_q;
	logic [WAY_W-1:0] way_q;
	logic             hit_q;

	logic [PTR_W-1:0] ptr_q;
	logic [9:0]       psel_q;
	logic [11:0]      upd_cnt_q;
	logic [WAY_W-1:0] victim_q;
	logic [1:0]       top_q;

	// row memories: one row of 2-bit fields per set
	logic [ROW_W-1:0] rrpv_mem  [NUM_SETS];
	logic [ROW_W-1:0] reuse_mem [NUM_SETS];
	logic [ROW_W-1:0] rrpv_rd_q, reuse_rd_q;

	logic             rd_en;
	logic [SET_W-1:0] rd_addr;
	logic             rrpv_we, reuse_we;
	logic [SET_W-1:0] wr_addr;
	logic [ROW_W-1:0] rrpv_wdata, reuse_wdata;

	logic in_xfer, out_xfer;
	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// lowest invalid way of the request
	logic             has_free;
	logic [WAY_W-1:0] free_way;
	always_comb begin
		has_free = 1'b0;
		free_way = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (!valid_mask[w]) begin
				has_free = 1'b1;
				free_way = WAY_W'(w);
			end
		end
	end

	// oldest rrpv in the set row
	logic [1:0] top_d;
	always_comb begin
		logic any3, anyhi, anylo;
		any3 = 1'b0;
		anyhi = 1'b0;
		anylo = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			any3  = any3 | (&rrpv_rd_q[2*w +: 2]);
			anyhi = anyhi | rrpv_rd_q[2*w+1];
			anylo = anylo | rrpv_rd_q[2*w];
		end
		if (anyhi) top_d = any3 ? 2'd3 : 2'd2;
		else       top_d = anylo ? 2'd1 : 2'd0;
	end

	// aged row and first way at distant rrpv
	logic [ROW_W-1:0] aged_row;
	logic [WAY_W-1:0] aged_way;
	always_comb begin
		logic [1:0] age;
		age = 2'd3 - top_q;
		aged_way = '0;
		for (int w = 0; w < NUM_WAYS; w++)
			aged_row[2*w +: 2] = rrpv_rd_q[2*w +: 2] + age;
		for (int w = NUM_WAYS - 1; w >= 0; w--)
			if (&aged_row[2*w +: 2]) aged_way = WAY_W'(w);
	end

	// sweep row: every reuse counter down by one, floor at zero
	logic [ROW_W-1:0] decay_row;
	always_comb begin
		for (int w = 0; w < NUM_WAYS; w++)
			decay_row[2*w +: 2] = (reuse_rd_q[2*w +: 2] == 2'd0) ?
				2'd0 : reuse_rd_q[2*w +: 2] - 2'd1;
	end

	// update of one line
	logic [1:0]       cur_rc, new_rrpv, new_rc;
	logic             lip_ldr, bip_ldr, leader, bypass, lip, insert;
	logic [ROW_W-1:0] upd_rrpv_row, upd_reuse_row;
	always_comb begin
		cur_rc  = reuse_rd_q[2*way_q +: 2];
		bip_ldr = set_q[STRIDE_W-1:0] == STRIDE_W'(STRIDE / 2);
		lip_ldr = !bip_ldr && (set_q[STRIDE_W-1:0] == '0);
		leader  = lip_ldr || bip_ldr;
		bypass  = !hit_q && leader && (cur_rc == 2'd0);
		lip     = lip_ldr || (!leader && (psel_q < PSEL_MID));
		insert  = !hit_q && !bypass;
		if (hit_q) begin
			new_rrpv = 2'd0;
			new_rc   = (cur_rc == 2'd3) ? 2'd3 : cur_rc + 2'd1;
		end else if (bypass) begin
			new_rrpv = 2'd3;
			new_rc   = cur_rc;
		end else begin
			if (cur_rc >= 2'd2)            new_rrpv = 2'd0;
			else if (lip)                  new_rrpv = 2'd3;
			else if (upd_cnt_q[4:0] == '0) new_rrpv = 2'd0;
			else                           new_rrpv = 2'd3;
			new_rc = 2'd1;
		end
		upd_rrpv_row  = rrpv_rd_q;
		upd_reuse_row = reuse_rd_q;
		upd_rrpv_row[2*way_q +: 2]  = new_rrpv;
		upd_reuse_row[2*way_q +: 2] = new_rc;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (ptr_q == PTR_W'(NUM_SETS - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_xfer) begin
					if (func == FUNC_VICTIM)
						state_d = has_free ? ST_OUT : ST_EXEC;
					else
						state_d = (upd_cnt_q == UPD_LAST) ? ST_SWEEP : ST_EXEC;
				end
			end
			ST_SWEEP: if (ptr_q == PTR_W'(NUM_SETS)) state_d = ST_READ;
			ST_READ:  state_d = ST_EXEC;
			ST_EXEC:  state_d = (func_q == FUNC_VICTIM) ? ST_AGE : ST_IDLE;
			ST_AGE:   state_d = ST_OUT;
			ST_OUT:   if (out_xfer) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = set_q;
		rrpv_we     = 1'b0;
		reuse_we    = 1'b0;
		wr_addr     = set_q;
		rrpv_wdata  = upd_rrpv_row;
		reuse_wdata = upd_reuse_row;
		case (state_q)
			ST_CLEAR: begin
				rrpv_we     = 1'b1;
				reuse_we    = 1'b1;
				wr_addr     = ptr_q[SET_W-1:0];
				rrpv_wdata  = {NUM_WAYS{2'd3}};
				reuse_wdata = {NUM_WAYS{2'd1}};
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				rd_en    = in_valid;
				rd_addr  = set_index;
			end
			ST_SWEEP: begin
				// read row n while row n-1 is written back
				rd_en       = !ptr_q[PTR_W-1];
				rd_addr     = ptr_q[SET_W-1:0];
				reuse_we    = ptr_q != '0;
				wr_addr     = ptr_q[SET_W-1:0] - SET_W'(1);
				reuse_wdata = decay_row;
			end
			ST_READ: rd_en = 1'b1;
			ST_EXEC: begin
				rrpv_we  = func_q == FUNC_UPDATE;
				reuse_we = func_q == FUNC_UPDATE;
			end
			ST_AGE: begin
				rrpv_we    = 1'b1;
				rrpv_wdata = aged_row;
			end
			ST_OUT:  out_valid = 1'b1;
			default: ;
		endcase
	end

	assign victim_way = victim_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rrpv_rd_q  <= rrpv_mem[rd_addr];
			reuse_rd_q <= reuse_mem[rd_addr];
		end
		if (rrpv_we)  rrpv_mem[wr_addr]  <= rrpv_wdata;
		if (reuse_we) reuse_mem[wr_addr] <= reuse_wdata;
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q <= func;
			set_q  <= set_index;
			way_q  <= way_index;
			hit_q  <= hit;
		end
		if (state_q == ST_EXEC) top_q <= top_d;
		if (in_xfer && has_free) victim_q <= free_way;
		else if (state_q == ST_AGE) victim_q <= aged_way;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			ptr_q     <= '0;
			psel_q    <= PSEL_MID;
			upd_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR || state_q == ST_SWEEP)
				ptr_q <= (state_d == state_q) ? ptr_q + PTR_W'(1) : '0;
			if (in_xfer && func == FUNC_UPDATE)
				upd_cnt_q <= upd_cnt_q + 12'd1;
			if (state_q == ST_EXEC && func_q == FUNC_UPDATE && insert) begin
				if (lip_ldr && psel_q != '0)      psel_q <= psel_q - 10'd1;
				if (bip_ldr && psel_q != PSEL_MAX) psel_q <= psel_q + 10'd1;
			end
		end
	end

endmodule
